@@ src/vtg_pkg.sv @@
// ----------------------------------------------------------------------------
// vtg_pkg: shared types and constants of the vector-tile geometry decoder
// Command ids, result kinds, the result record and the zigzag decode helper.
// ----------------------------------------------------------------------------
`default_nettype none

package vtg_pkg;

	localparam int WORD_W     = 32;
	localparam int CMD_ID_W   = 3;
	localparam int COUNT_W    = WORD_W - CMD_ID_W;
	localparam int KIND_W     = 2;
	localparam int OUT_DATA_W = 200;
	localparam int QUEUE_DEPTH = 3;
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CMD_ID_W-1:0] ID_MOVETO = 3'd1;
	localparam logic [CMD_ID_W-1:0] ID_LINETO = 3'd2;
	localparam logic [CMD_ID_W-1:0] ID_CLOSE  = 3'd7;

	localparam logic [KIND_W-1:0] KIND_MOVETO  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINETO  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

	localparam logic signed [WORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] box_min_x;
		logic signed [WORD_W-1:0] box_min_y;
		logic signed [WORD_W-1:0] box_max_x;
		logic signed [WORD_W-1:0] box_max_y;
		logic                     box_valid;
		logic                     truncated;
		logic                     end_of_run;
	} result_t;

	// Zigzag decode: the low bit carries the sign.
	function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] n);
		zigzag = (n >> 1) ^ {WORD_W{n[0]}};
	endfunction

endpackage

`default_nettype wire

@@ src/vtg_decode.sv @@
// ----------------------------------------------------------------------------
// vtg_decode: geometry command decode and feature state
// Turns one registered word into up to two results and updates the cursor,
// the run state and the bounding box when the word is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module vtg_decode #(
	parameter int COORD_BITS = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          fire,
	input  wire [vtg_pkg::WORD_W-1:0]    word,
	input  wire                          last_word,
	output vtg_pkg::result_t             res0,
	output vtg_pkg::result_t             res1,
	output logic [1:0]                   res_n
);
	import vtg_pkg::*;

	logic [COORD_BITS-1:0]    cursor_x_q, cursor_y_q, cursor_x_d, cursor_y_d;
	logic signed [WORD_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic signed [WORD_W-1:0] min_x_d, min_y_d, max_x_d, max_y_d;
	logic [COUNT_W-1:0]       pairs_left_q, pairs_left_d;
	logic                     run_kind_q, run_kind_d;
	logic                     have_dx_q, have_dx_d;
	logic [COORD_BITS-1:0]    held_dx_q, held_dx_d;
	logic                     any_point_q, any_point_d;

	logic [WORD_W-1:0]        zz;
	logic [CMD_ID_W-1:0]      cmd_id;
	logic [COORD_BITS-1:0]    nx, ny;
	logic signed [WORD_W-1:0] px, py, cx_ext, cy_ext;
	logic                     in_run;
	result_t                  first_res, summary;
	logic                     has_first;

	assign zz     = zigzag(word);
	assign cmd_id = word[CMD_ID_W-1:0];
	assign in_run = (pairs_left_q != '0);
	assign nx     = cursor_x_q + held_dx_q;
	assign ny     = cursor_y_q + zz[COORD_BITS-1:0];
	assign px     = WORD_W'(signed'(nx));
	assign py     = WORD_W'(signed'(ny));

	always_comb begin
		cursor_x_d   = cursor_x_q;
		cursor_y_d   = cursor_y_q;
		min_x_d      = min_x_q;
		min_y_d      = min_y_q;
		max_x_d      = max_x_q;
		max_y_d      = max_y_q;
		pairs_left_d = pairs_left_q;
		run_kind_d   = run_kind_q;
		have_dx_d    = have_dx_q;
		held_dx_d    = held_dx_q;
		any_point_d  = any_point_q;
		first_res    = '0;
		has_first    = 1'b0;

		if (in_run) begin
			if (!have_dx_q) begin
				held_dx_d = zz[COORD_BITS-1:0];
				have_dx_d = 1'b1;
			end else begin
				cursor_x_d   = nx;
				cursor_y_d   = ny;
				have_dx_d    = 1'b0;
				pairs_left_d = pairs_left_q - COUNT_W'(1);
				if (px < min_x_q) min_x_d = px;
				if (py < min_y_q) min_y_d = py;
				if (px > max_x_q) max_x_d = px;
				if (py > max_y_q) max_y_d = py;
				any_point_d     = 1'b1;
				first_res.kind  = run_kind_q ? KIND_LINETO : KIND_MOVETO;
				first_res.pos_x = px;
				first_res.pos_y = py;
				has_first       = 1'b1;
			end
		end else if (cmd_id == ID_MOVETO || cmd_id == ID_LINETO) begin
			pairs_left_d = word[WORD_W-1:CMD_ID_W];
			run_kind_d   = (cmd_id == ID_LINETO);
			have_dx_d    = 1'b0;
		end else if (cmd_id == ID_CLOSE) begin
			first_res.kind  = KIND_CLOSE;
			first_res.pos_x = WORD_W'(signed'(cursor_x_q));
			first_res.pos_y = WORD_W'(signed'(cursor_y_q));
			has_first       = 1'b1;
		end

		// The summary reports the state left behind by this word.
		cx_ext            = WORD_W'(signed'(cursor_x_d));
		cy_ext            = WORD_W'(signed'(cursor_y_d));
		summary           = '0;
		summary.kind      = KIND_SUMMARY;
		summary.pos_x     = cx_ext;
		summary.pos_y     = cy_ext;
		summary.truncated = (pairs_left_d != '0) || have_dx_d;
		summary.end_of_run = 1'b1;
		if (any_point_d) begin
			summary.box_min_x = min_x_d;
			summary.box_min_y = min_y_d;
			summary.box_max_x = max_x_d;
			summary.box_max_y = max_y_d;
			summary.box_valid = 1'b1;
		end

		res1 = '0;
		if (last_word) begin
			if (has_first) begin
				res0  = first_res;
				res1  = summary;
				res_n = 2'd2;
			end else begin
				res0  = summary;
				res_n = 2'd1;
			end
			// The feature is finished: back to the reset state.
			cursor_x_d   = '0;
			cursor_y_d   = '0;
			min_x_d      = COORD_MAX;
			min_y_d      = COORD_MAX;
			max_x_d      = COORD_MIN;
			max_y_d      = COORD_MIN;
			pairs_left_d = '0;
			run_kind_d   = 1'b0;
			have_dx_d    = 1'b0;
			held_dx_d    = '0;
			any_point_d  = 1'b0;
		end else begin
			res0            = first_res;
			res0.end_of_run = has_first;
			res_n           = has_first ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			min_x_q      <= COORD_MAX;
			min_y_q      <= COORD_MAX;
			max_x_q      <= COORD_MIN;
			max_y_q      <= COORD_MIN;
			pairs_left_q <= '0;
			run_kind_q   <= 1'b0;
			have_dx_q    <= 1'b0;
			held_dx_q    <= '0;
			any_point_q  <= 1'b0;
		end else if (fire) begin
			cursor_x_q   <= cursor_x_d;
			cursor_y_q   <= cursor_y_d;
			min_x_q      <= min_x_d;
			min_y_q      <= min_y_d;
			max_x_q      <= max_x_d;
			max_y_q      <= max_y_d;
			pairs_left_q <= pairs_left_d;
			run_kind_q   <= run_kind_d;
			have_dx_q    <= have_dx_d;
			held_dx_q    <= held_dx_d;
			any_point_q  <= any_point_d;
		end
	end

endmodule

`default_nettype wire

@@ src/vtg_outq.sv @@
// ----------------------------------------------------------------------------
// vtg_outq: result queue
// A short shift queue that takes up to two results per cycle when it has
// room and hands one result per cycle to the port while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module vtg_outq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire vtg_pkg::result_t push0,
	input  wire vtg_pkg::result_t push1,
	input  wire  [1:0]          push_n,
	output logic                room,
	output logic                out_valid,
	input  wire                 out_ready,
	output vtg_pkg::result_t    out_res
);
	import vtg_pkg::*;

	result_t             slot_q [QUEUE_DEPTH];
	logic [QCNT_W-1:0]   cnt_q;
	logic [QCNT_W-1:0]   cnt_p;
	logic                pop;

	assign out_valid = (cnt_q != '0);
	assign out_res   = slot_q[0];
	assign pop       = out_valid && out_ready;
	assign cnt_p     = cnt_q - QCNT_W'(pop);
	// Two free entries after this cycle's pop make room for any item.
	assign room      = (cnt_p <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (push_n != 2'd0 && cnt_p == QCNT_W'(i)) begin
				slot_q[i] <= push0;
			end else if (push_n == 2'd2 && cnt_p + QCNT_W'(1) == QCNT_W'(i)) begin
				slot_q[i] <= push1;
			end else if (pop && i < QUEUE_DEPTH - 1) begin
				slot_q[i] <= slot_q[(i + 1) % QUEUE_DEPTH];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_p + QCNT_W'(push_n);
		end
	end

endmodule

`default_nettype wire

@@ src/vector_tile_geometry_decoder.sv @@
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder: vector-tile geometry command stream decoder
// Decodes MoveTo, LineTo and ClosePath commands with zigzag parameter pairs,
// emits points and close markers, and a bounding-box summary per feature.
// ----------------------------------------------------------------------------
// The block takes one geometry word per item, with tlast marking the final
// word of a feature. An item is first captured in an input register; once
// the queue has room, a single pass of decode logic consumes it, updates the
// cursor, the run state and the bounding box, and writes its results into a
// three-entry result queue that drives the output port. The block accepts
// one item per clock cycle while the result queue has room. Most items give
// zero or one result; the last word of a feature that also completes a point
// or carries ClosePath gives two (the point or close marker, then the
// summary), and the output port delivers one result per cycle while
// m_axis_tready is high, so such an item takes two queue entries. A result
// passes through the input register and a queue slot before it appears on
// the output. Cursor arithmetic wraps at COORD_BITS bits and positions are
// reported sign-extended to 32 bits. Command words with ids other than
// MoveTo, LineTo and ClosePath are ignored; they give no result but the
// summary when they end a feature.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_tile_geometry_decoder #(
	parameter int COORD_BITS = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: word[31:0]
	input  wire  [vtg_pkg::WORD_W-1:0]          s_axis_tdata,
	input  wire                                 s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// tdata: pos_x, pos_y, box_min_x, box_min_y, box_max_x, box_max_y,
	// box_valid, truncated, then zero fill to 200 bits.
	output logic [vtg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// tuser: kind[1:0]
	output logic [vtg_pkg::KIND_W-1:0]          m_axis_tuser,
	output logic                                m_axis_tlast
);
	import vtg_pkg::*;

	// Input register.
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              last_s1;

	logic              fire;
	logic              room;
	result_t           res0, res1, out_res;
	logic [1:0]        res_n;

	// The registered item is consumed once the queue can hold both of its
	// possible results; a new item enters whenever the register frees up.
	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			word_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	vtg_decode #(
		.COORD_BITS(COORD_BITS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.word      (word_s1),
		.last_word (last_s1),
		.res0      (res0),
		.res1      (res1),
		.res_n     (res_n)
	);

	vtg_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (res0),
		.push1     (res1),
		.push_n    (fire ? res_n : 2'd0),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the result record onto the stream, first field in the low bits.
	assign m_axis_tdata = {6'd0, out_res.truncated, out_res.box_valid,
		out_res.box_max_y, out_res.box_max_x, out_res.box_min_y,
		out_res.box_min_x, out_res.pos_y, out_res.pos_x};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.end_of_run;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the vector-tile geometry decoder
// Streams geometry words (directed features first, then random features that
// are mostly well-formed command runs) into the decoder. It predicts every
// point, close marker and feature summary, and checks each output item in
// order. Both stream sides idle at random in several phases.
// ----------------------------------------------------------------------------

module tb;

	import vtg_pkg::*;

	localparam int COORD_BITS = 32;
	// Generous bound; a correct run with the heaviest idling needs far fewer.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 1700;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the decoder state, turns each accepted
	// word into the results it must cause, and compares output items in order.
	// ------------------------------------------------------------------------
	class geometry_scoreboard #(int COORD_BITS = 32);

		result_t results_due[$];

		// Cursor and box, held sign-extended from COORD_BITS.
		logic signed [WORD_W-1:0] cur_x, cur_y;
		logic signed [WORD_W-1:0] lo_x, lo_y, hi_x, hi_y;
		logic [COUNT_W-1:0] pairs_due;
		logic [KIND_W-1:0] pair_kind;
		bit half_pair;
		logic [WORD_W-1:0] held_dx;
		bit seen_point;

		int errors;
		int n_words, n_points, n_closes, n_summaries, n_truncated, n_empty;

		function new();
			clear_feature();
		endfunction

		function void clear_feature();
			cur_x = '0;
			cur_y = '0;
			lo_x = COORD_MAX;
			lo_y = COORD_MAX;
			hi_x = COORD_MIN;
			hi_y = COORD_MIN;
			pairs_due = '0;
			pair_kind = KIND_MOVETO;
			half_pair = 1'b0;
			held_dx = '0;
			seen_point = 1'b0;
		endfunction

		// Keep the low COORD_BITS bits and sign-extend them to a full word.
		function logic signed [WORD_W-1:0] wrap_coord(logic [WORD_W-1:0] v);
			logic signed [WORD_W-1:0] t;
			t = v << (WORD_W - COORD_BITS);
			return t >>> (WORD_W - COORD_BITS);
		endfunction

		// Parameter words carry the sign in bit 0, magnitude above it.
		function logic [WORD_W-1:0] delta_of(logic [WORD_W-1:0] n);
			return n[0] ? ~(n >> 1) : (n >> 1);
		endfunction

		function result_t cursor_result(logic [KIND_W-1:0] kind, bit eor);
			result_t r;
			r = '0;
			r.kind = kind;
			r.pos_x = cur_x;
			r.pos_y = cur_y;
			r.end_of_run = eor;
			return r;
		endfunction

		function void note_word(logic [WORD_W-1:0] w, bit is_last);
			logic [CMD_ID_W-1:0] id;
			result_t sum;
			n_words++;
			id = w[CMD_ID_W-1:0];
			if (pairs_due != 0) begin
				if (!half_pair) begin
					held_dx = w;
					half_pair = 1'b1;
				end else begin
					cur_x = wrap_coord(cur_x + delta_of(held_dx));
					cur_y = wrap_coord(cur_y + delta_of(w));
					half_pair = 1'b0;
					pairs_due = pairs_due - 1'b1;
					if (cur_x < lo_x) lo_x = cur_x;
					if (cur_y < lo_y) lo_y = cur_y;
					if (cur_x > hi_x) hi_x = cur_x;
					if (cur_y > hi_y) hi_y = cur_y;
					seen_point = 1'b1;
					n_points++;
					results_due = {results_due, cursor_result(pair_kind, !is_last)};
				end
			end else if (id == ID_MOVETO || id == ID_LINETO) begin
				pairs_due = w[WORD_W-1:CMD_ID_W];
				pair_kind = (id == ID_MOVETO) ? KIND_MOVETO : KIND_LINETO;
				half_pair = 1'b0;
			end else if (id == ID_CLOSE) begin
				// The count bits of a close command are don't-care.
				n_closes++;
				results_due = {results_due, cursor_result(KIND_CLOSE, !is_last)};
			end
			if (is_last) begin
				sum = cursor_result(KIND_SUMMARY, 1'b1);
				if (seen_point) begin
					sum.box_min_x = lo_x;
					sum.box_min_y = lo_y;
					sum.box_max_x = hi_x;
					sum.box_max_y = hi_y;
					sum.box_valid = 1'b1;
				end else begin
					n_empty++;
				end
				// A held dx or pairs still owed means the feature was cut short.
				sum.truncated = (pairs_due != 0) || half_pair;
				if (sum.truncated) n_truncated++;
				n_summaries++;
				results_due = {results_due, sum};
				clear_feature();
			end
		endfunction

		task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
			if (errors < 40)
				$display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (results_due.size() == 0) begin
				report("result of this kind with nothing expected", got.kind, '0);
				return;
			end
			want = results_due.pop_front();
			if (got.kind != want.kind) report("kind", got.kind, want.kind);
			if (got.pos_x != want.pos_x) report("pos_x", got.pos_x, want.pos_x);
			if (got.pos_y != want.pos_y) report("pos_y", got.pos_y, want.pos_y);
			if (got.box_min_x != want.box_min_x)
				report("box_min_x", got.box_min_x, want.box_min_x);
			if (got.box_min_y != want.box_min_y)
				report("box_min_y", got.box_min_y, want.box_min_y);
			if (got.box_max_x != want.box_max_x)
				report("box_max_x", got.box_max_x, want.box_max_x);
			if (got.box_max_y != want.box_max_y)
				report("box_max_y", got.box_max_y, want.box_max_y);
			if (got.box_valid != want.box_valid)
				report("box_valid", got.box_valid, want.box_valid);
			if (got.truncated != want.truncated)
				report("truncated", got.truncated, want.truncated);
			if (got.end_of_run != want.end_of_run)
				report("end_of_run", got.end_of_run, want.end_of_run);
		endtask

		task check_drained();
			result_t want;
			while (results_due.size() != 0) begin
				want = results_due.pop_front();
				report("missing result of this kind", '0, want.kind);
			end
		endtask

		function int pending();
			return results_due.size();
		endfunction

	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block under test.
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [WORD_W-1:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	geometry_scoreboard #(COORD_BITS) sb;

	// Stimulus: one geometry word per entry, with its end-of-feature flag.
	logic [WORD_W-1:0] stim_word[$];
	bit stim_last[$];
	int n_directed;
	int n_features;

	int send_idle_pct;
	int recv_stall_pct;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	vector_tile_geometry_decoder #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	function automatic logic [WORD_W-1:0] command(logic [CMD_ID_W-1:0] id,
			logic [COUNT_W-1:0] count);
		return {count, id};
	endfunction

	// Parameter word for a signed delta: sign goes to bit 0.
	function automatic logic [WORD_W-1:0] param_of(int d);
		return (d << 1) ^ (d >>> 31);
	endfunction

	// Any command id the decoder is meant to skip.
	function automatic logic [CMD_ID_W-1:0] unknown_id();
		logic [CMD_ID_W-1:0] id;
		do
			id = CMD_ID_W'($urandom_range(0, 7));
		while (id == ID_MOVETO || id == ID_LINETO || id == ID_CLOSE);
		return id;
	endfunction

	// Mostly small deltas; some full-width words and some extremes so the
	// cursor wraps and the signed box compares see both ends of the range.
	function automatic logic [WORD_W-1:0] random_param();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			return $urandom();
		else if (sel == 2)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 1)
				: $urandom_range(0, 1);
		else
			return $urandom_range(0, 400);
	endfunction

	function automatic logic [COUNT_W-1:0] random_count();
		return COUNT_W'(($urandom_range(0, 9) == 0) ? $urandom() >> CMD_ID_W
			: $urandom_range(0, 3));
	endfunction

	task automatic push_word(logic [WORD_W-1:0] w, bit is_last);
		stim_word = {stim_word, w};
		stim_last = {stim_last, is_last};
	endtask

	// One random feature: a handful of commands, each run with its parameters.
	// A run with a huge count can never complete, so the feature ends inside
	// it. Some features are cut at a random word, which can leave a partial pair.
	task automatic add_feature();
		int start;
		int ncmd;
		int sel;
		int keep;
		logic [COUNT_W-1:0] count;
		bit cut_short;
		start = stim_word.size();
		ncmd = $urandom_range(1, 6);
		cut_short = 1'b0;
		for (int c = 0; c < ncmd && !cut_short; c++) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				count = COUNT_W'(($urandom_range(0, 19) == 0) ? $urandom() >> CMD_ID_W
					: $urandom_range(0, 5));
				push_word(command(sel < 25 ? ID_MOVETO : ID_LINETO, count), 1'b0);
				if (count > 8) begin
					repeat ($urandom_range(0, 5)) push_word(random_param(), 1'b0);
					cut_short = 1'b1;
				end else begin
					repeat (2 * count) push_word(random_param(), 1'b0);
				end
			end else if (sel < 80) begin
				push_word(command(ID_CLOSE, random_count()), 1'b0);
			end else if (sel < 92) begin
				push_word(command(unknown_id(), random_count()), 1'b0);
			end else begin
				push_word($urandom(), 1'b0);
			end
		end
		if ($urandom_range(0, 99) < 12) begin
			keep = $urandom_range(1, stim_word.size() - start);
			while (stim_word.size() > start + keep) begin
				void'(stim_word.pop_back());
				void'(stim_last.pop_back());
			end
		end
		stim_last[stim_last.size() - 1] = 1'b1;
		n_features++;
	endtask

	task automatic build_stimulus();
		// Close at the origin; every count bit set and ignored.
		push_word(command(ID_CLOSE, '1), 1'b0);
		// Most negative dx and most positive dy in one moveto.
		push_word(command(ID_MOVETO, COUNT_W'(1)), 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'hFFFF_FFFE, 1'b0);
		// Lineto with two pairs that move x and y inward from the range ends.
		push_word(command(ID_LINETO, COUNT_W'(2)), 1'b0);
		push_word(param_of(1), 1'b0);
		push_word(param_of(-1), 1'b0);
		push_word(param_of(0), 1'b0);
		push_word(param_of(-2), 1'b0);
		// Every id that the decoder skips.
		for (int k = 0; k < 8; k++)
			if (k[CMD_ID_W-1:0] != ID_MOVETO && k[CMD_ID_W-1:0] != ID_LINETO &&
					k[CMD_ID_W-1:0] != ID_CLOSE)
				push_word(command(k[CMD_ID_W-1:0], COUNT_W'(k)), 1'b0);
		// Zero-count run, then a close on the last word: close plus summary.
		push_word(command(ID_MOVETO, COUNT_W'(0)), 1'b0);
		push_word(command(ID_CLOSE, COUNT_W'(0)), 1'b1);
		// Feature of one skipped word: summary with an empty box.
		push_word(command(unknown_id(), COUNT_W'(0)), 1'b1);
		// Last word completes a point: point plus summary.
		push_word(command(ID_LINETO, COUNT_W'(2)), 1'b0);
		push_word(param_of(5), 1'b0);
		push_word(param_of(-7), 1'b0);
		push_word(param_of(100), 1'b0);
		push_word(param_of(3), 1'b1);
		// Ends holding a dx word.
		push_word(command(ID_MOVETO, COUNT_W'(3)), 1'b0);
		push_word(param_of(1), 1'b0);
		push_word(param_of(1), 1'b0);
		push_word(param_of(9), 1'b1);
		// Ends on a run command that still owes pairs, then on an empty run.
		push_word(command(ID_LINETO, COUNT_W'(4)), 1'b1);
		push_word(command(ID_MOVETO, COUNT_W'(0)), 1'b1);
		n_directed = stim_word.size();
		while (stim_word.size() < n_directed + RANDOM_WORDS)
			add_feature();
	endtask

	// ------------------------------------------------------------------------
	// Monitors. Both sample at the clock edge, before any update of that edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_word(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_t got;
			got = '0;
			got.kind = m_axis_tuser;
			got.pos_x = m_axis_tdata[31:0];
			got.pos_y = m_axis_tdata[63:32];
			got.box_min_x = m_axis_tdata[95:64];
			got.box_min_y = m_axis_tdata[127:96];
			got.box_max_x = m_axis_tdata[159:128];
			got.box_max_y = m_axis_tdata[191:160];
			got.box_valid = m_axis_tdata[192];
			got.truncated = m_axis_tdata[193];
			got.end_of_run = m_axis_tlast;
			sb.check_result(got);
		end
	end

	// Receiver: stalls at the rate set by the current phase.
	always @(posedge clk) begin
		if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, sb.pending());
			$display("tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		int phase;
		int n_random;
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		n_features = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		build_stimulus();
		n_random = stim_word.size() - n_directed;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < stim_word.size(); i++) begin
			// The directed words go without idling; the random part is split
			// into five stretches: none, sender idle, receiver stall, both, none.
			phase = (i < n_directed) ? 0 : ((i - n_directed) * 5) / n_random;
			case (phase)
				1: begin
					send_idle_pct = 75;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 75;
				end
				3: begin
					send_idle_pct = 32;
					recv_stall_pct <= 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
			endcase
			while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= stim_word[i];
			s_axis_tlast <= stim_last[i];
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b0;

		// Let the result queue drain, then watch a while for stray items.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		sb.check_drained();

		$display("Sent %0d words (%0d directed) in %0d random features plus directed ones.",
			sb.n_words, n_directed, n_features);
		$display("Checked %0d points, %0d close markers, %0d summaries (%0d truncated, %0d empty).",
			sb.n_points, sb.n_closes, sb.n_summaries, sb.n_truncated, sb.n_empty);
		if (sb.errors == 0) begin
			$display("tb OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
